// ----- rtl/sps_pkg.sv -----
// shared types, codes and sizes for the support point search unit
package sps_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_W          = 32;
    localparam int MODE_W           = 2;
    localparam int STATUS_W         = 3;
    localparam int IDX_OUT_W        = 6;
    localparam int PROD_W           = 2 * COORD_W;
    localparam int SUM_W            = PROD_W + 2;
    localparam int DATA_IN_W        = 3 * COORD_W;
    localparam int DATA_OUT_W       = 104;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_QUERY = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED   = 3'd0,
        ST_FULL     = 3'd1,
        ST_ANSWERED = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    wr_vertex;
        logic    clr_count;
        logic    start_query;
        logic    issue_rd;
        logic    put_result;
        t_status put_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic last_rd;
        logic pipe_busy;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/sps_ctrl.sv -----
// controller state machine for the support point search unit
module sps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_mode,
    output logic          o_in_ready,
    input  sps_pkg::t_stat i_stat,
    output sps_pkg::t_cmd  o_cmd
);
    import sps_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_mode == MODE_QUERY) && !i_stat.empty) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.last_rd) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_cmd.put_status = ST_LOADED;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_LOAD: begin
                            o_cmd.put_result = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.put_status = ST_FULL;
                            end else begin
                                o_cmd.wr_vertex  = 1'b1;
                                o_cmd.put_status = ST_LOADED;
                            end
                        end
                        MODE_CLEAR: begin
                            o_cmd.clr_count  = 1'b1;
                            o_cmd.put_result = 1'b1;
                            o_cmd.put_status = ST_CLEARED;
                        end
                        MODE_QUERY: begin
                            if (i_stat.empty) begin
                                o_cmd.put_result = 1'b1;
                                o_cmd.put_status = ST_EMPTY;
                            end else begin
                                o_cmd.start_query = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.issue_rd = 1'b1;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.put_result = 1'b1;
                    o_cmd.put_status = ST_ANSWERED;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/sps_dpath.sv -----
// vertex memory, dot product pipeline, best tracker and result register
module sps_dpath #(
    parameter int MAX_VERTICES = sps_pkg::MAX_VERTICES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sps_pkg::t_cmd                       i_cmd,
    output sps_pkg::t_stat                      o_stat,
    input  logic signed [sps_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [sps_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [sps_pkg::COORD_W-1:0]  i_coord_z,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [sps_pkg::STATUS_W-1:0]        o_status,
    output logic signed [sps_pkg::COORD_W-1:0]  o_best_x,
    output logic signed [sps_pkg::COORD_W-1:0]  o_best_y,
    output logic signed [sps_pkg::COORD_W-1:0]  o_best_z,
    output logic [sps_pkg::IDX_OUT_W-1:0]       o_best_index
);
    import sps_pkg::*;

    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int EXT_W = (AW > IDX_OUT_W) ? AW : IDX_OUT_W;

    logic [DATA_IN_W-1:0] r_mem [MAX_VERTICES];

    logic [CW-1:0] r_count;
    logic [AW-1:0] r_rd_addr;
    logic signed [COORD_W-1:0] r_dir_x, r_dir_y, r_dir_z;

    // stage 1: memory read
    logic                 r_v1;
    logic [AW-1:0]        r_i1;
    logic [DATA_IN_W-1:0] r_c1;
    // stage 2: products
    logic                     r_v2;
    logic [AW-1:0]            r_i2;
    logic [DATA_IN_W-1:0]     r_c2;
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    // stage 3: sum
    logic                    r_v3;
    logic [AW-1:0]           r_i3;
    logic [DATA_IN_W-1:0]    r_c3;
    logic signed [SUM_W-1:0] r_sum;
    // best so far
    logic signed [SUM_W-1:0] r_best_sum;
    logic [AW-1:0]           r_best_idx;
    logic [DATA_IN_W-1:0]    r_best_c;
    // result word
    logic                    r_out_valid;
    t_status                 r_status;
    logic [DATA_IN_W-1:0]    r_out_c;
    logic [IDX_OUT_W-1:0]    r_out_idx;

    logic [EXT_W-1:0]        best_idx_ext;
    logic signed [SUM_W-1:0] sum_next;
    logic                    take;

    assign o_stat.full      = (r_count == CW'(MAX_VERTICES));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.last_rd   = ((CW'(r_rd_addr) + CW'(1)) == r_count);
    assign o_stat.pipe_busy = r_v1 | r_v2 | r_v3;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vertex) begin
            r_mem[r_count[AW-1:0]] <= {i_coord_z, i_coord_y, i_coord_x};
        end
        r_c1 <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clr_count) begin
            r_count <= '0;
        end else if (i_cmd.wr_vertex) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
        end else if (i_cmd.start_query) begin
            r_rd_addr <= '0;
        end else if (i_cmd.issue_rd) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_query) begin
            r_dir_x <= i_coord_x;
            r_dir_y <= i_coord_y;
            r_dir_z <= i_coord_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue_rd;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload pipeline, one multiplier per axis with a register behind it
    always_ff @(posedge i_clk) begin
        r_i1 <= r_rd_addr;
        r_i2 <= r_i1;
        r_c2 <= r_c1;
        r_px <= r_dir_x * $signed(r_c1[COORD_W-1:0]);
        r_py <= r_dir_y * $signed(r_c1[2*COORD_W-1:COORD_W]);
        r_pz <= r_dir_z * $signed(r_c1[3*COORD_W-1:2*COORD_W]);
        r_i3 <= r_i2;
        r_c3 <= r_c2;
        r_sum <= sum_next;
    end

    assign sum_next = SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz);

    // earliest vertex wins on a tie, so only a strictly greater sum replaces
    assign take = r_v3 && ((r_i3 == '0) || (r_sum > r_best_sum));

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_sum <= r_sum;
            r_best_idx <= r_i3;
            r_best_c   <= r_c3;
        end
    end

    assign best_idx_ext = EXT_W'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.put_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_result) begin
            r_status <= i_cmd.put_status;
            if (i_cmd.put_status == ST_ANSWERED) begin
                r_out_c   <= r_best_c;
                r_out_idx <= best_idx_ext[IDX_OUT_W-1:0];
            end else begin
                r_out_c   <= '0;
                r_out_idx <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_best_x     = $signed(r_out_c[COORD_W-1:0]);
    assign o_best_y     = $signed(r_out_c[2*COORD_W-1:COORD_W]);
    assign o_best_z     = $signed(r_out_c[3*COORD_W-1:2*COORD_W]);
    assign o_best_index = r_out_idx;

endmodule

// ----- rtl/support_point_search_unit.sv -----
// top level of the support point search unit
// The unit keeps a table of up to MAX_VERTICES vertices (signed Q16.16 x, y, z)
// and answers a query direction with the stored vertex of greatest dot product,
// the earliest loaded one on a tie, compared exactly at 66 bits. A load or a
// clear returns its status word at once; a load into a full
// table is dropped with status full. A query on an empty table returns status
// empty with zero fields. A query walks the vertex memory through one read port,
// one vertex per cycle, then three pipeline stages (memory read, multiply, add)
// and a compare into the best register. One word is worked on at a time; the
// result sits in an output register, and a new word is taken only while that
// register is empty or its word is being taken in the same cycle.
module support_point_search_unit #(
    parameter int MAX_VERTICES = sps_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sps_pkg::DATA_IN_W-1:0]     s_axis_tdata,  // coord_x, coord_y, coord_z
    input  logic [sps_pkg::MODE_W-1:0]        s_axis_tuser,  // mode
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sps_pkg::DATA_OUT_W-1:0]    m_axis_tdata,  // best_x, best_y, best_z, best_index
    output logic [sps_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);
    import sps_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    logic signed [COORD_W-1:0] best_x, best_y, best_z;
    logic [IDX_OUT_W-1:0]      best_index;

    // sequencer: accept, scan, drain, respond
    sps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // vertex table, dot product pipeline and result register
    sps_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_coord_x    (s_axis_tdata[COORD_W-1:0]),
        .i_coord_y    (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_coord_z    (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_status     (m_axis_tuser),
        .o_best_x     (best_x),
        .o_best_y     (best_y),
        .o_best_z     (best_z),
        .o_best_index (best_index)
    );

    // pack result word, zero fill to whole bytes
    assign m_axis_tdata = {
        (DATA_OUT_W - 3*COORD_W - IDX_OUT_W)'(0),
        best_index, best_z, best_y, best_x
    };

    // the scan pipeline is empty whenever a new word can be taken
    a_ready_pipe_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !stat.pipe_busy)
        else $error("input ready while scan pipeline still busy");

    // a result is never written over one that has not been taken
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.put_result |-> stat.out_free)
        else $error("result word overwritten before it was taken");

    // the scan only reads when the table holds vertices
    a_scan_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue_rd |-> !stat.empty)
        else $error("vertex read issued on an empty table");

    // the scan stops after the last stored vertex
    a_scan_stops : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.issue_rd && stat.last_rd) |=> !cmd.issue_rd)
        else $error("vertex read issued past the end of the table");

endmodule
